// ----- design/obq_pkg.sv -----
// package: shared types, codes and arithmetic widths of the oriented box query unit
package obq_pkg;

    localparam int AXIS_FRAC_BITS = 14;

    // intermediate widths
    localparam int MW   = 49;
    localparam int LW   = 50;
    localparam int RW   = 33;
    localparam int PW   = 32;
    localparam int TPW  = 63;
    localparam int TW   = 65;
    localparam int CMP_W = (LW + AXIS_FRAC_BITS > TW) ? LW + AXIS_FRAC_BITS + 1 : TW + 1;

    typedef enum logic [1:0] {
        ACT_CONTAINS = 2'd0,
        ACT_CLOSEST  = 2'd1,
        ACT_OVERLAP  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_AXIS_X      = 3'd2,
        REG_AXIS_Y      = 3'd3,
        REG_HALF_WIDTH  = 3'd4,
        REG_HALF_HEIGHT = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic [30:0]        half_width;
        logic [30:0]        half_height;
    } obq_cfg_t;

endpackage

// ----- design/obq_if.sv -----
// interfaces: query, result and configuration channels
interface obq_query_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] other_center_x;
    logic signed [31:0] other_center_y;
    logic signed [15:0] other_axis_x;
    logic signed [15:0] other_axis_y;
    logic [30:0]        other_half_width;
    logic [30:0]        other_half_height;

    modport source (output valid, action, point_x, point_y, other_center_x, other_center_y,
                    other_axis_x, other_axis_y, other_half_width, other_half_height,
                    input ready);
    modport sink (input valid, action, point_x, point_y, other_center_x, other_center_y,
                  other_axis_x, other_axis_y, other_half_width, other_half_height,
                  output ready);
endinterface

interface obq_result_if;
    logic               valid;
    logic               ready;
    logic               inside_res;
    logic signed [31:0] closest_x;
    logic signed [31:0] closest_y;
    logic               overlap;

    modport source (output valid, inside_res, closest_x, closest_y, overlap, input ready);
    modport sink (input valid, inside_res, closest_x, closest_y, overlap, output ready);
endinterface

interface obq_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- design/obq_cfg_regs.sv -----
// configuration register file of the oriented box query unit
module obq_cfg_regs
    import obq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    obq_cfg_if.sink  cfg,
    output obq_cfg_t regs
);

    obq_cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x    <= '0;
            cfg_reg.center_y    <= '0;
            cfg_reg.axis_x      <= 16'sd16384;
            cfg_reg.axis_y      <= '0;
            cfg_reg.half_width  <= 31'd65536;
            cfg_reg.half_height <= 31'd65536;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_CENTER_X:    cfg_reg.center_x    <= cfg.data;
                REG_CENTER_Y:    cfg_reg.center_y    <= cfg.data;
                REG_AXIS_X:      cfg_reg.axis_x      <= cfg.data[15:0];
                REG_AXIS_Y:      cfg_reg.axis_y      <= cfg.data[15:0];
                REG_HALF_WIDTH:  cfg_reg.half_width  <= cfg.data[30:0];
                REG_HALF_HEIGHT: cfg_reg.half_height <= cfg.data[30:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ----- design/oriented_box_query_unit.sv -----
// top level: seven stage pipeline answering contains, closest point and overlap queries
//
//  channel | dir | transaction
//  query   | in  | action, point, other box
//  result  | out | inside_res, closest point, overlap
//  cfg     | in  | register index and data
//
// result registered in stage 7, in query order; one query per cycle sustained while result.ready is high
// pipeline depth set by the multiply, wide add and compare stages of the overlap path
// each stage holds while the next is full and stalled; empty stages fill in under a stall
// reset empties the pipeline and loads the default unit box
module oriented_box_query_unit
    import obq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    obq_query_if.sink     query,
    obq_result_if.source  result,
    obq_cfg_if.sink       cfg
);

    localparam int A = AXIS_FRAC_BITS;
    localparam logic signed [LW-1:0] RND     = LW'(1) <<< (A - 1);
    localparam logic signed [LW-1:0] SAT_MAX = LW'(64'sd2147483647);
    localparam logic signed [LW-1:0] SAT_MIN = -LW'(64'sd2147483648);

    obq_cfg_t cfg_q;

    obq_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_q)
    );

    logic signed [15:0] rxa, rya;
    logic signed [31:0] cxa, cya;
    assign rxa = $signed(cfg_q.axis_x);
    assign rya = $signed(cfg_q.axis_y);
    assign cxa = $signed(cfg_q.center_x);
    assign cya = $signed(cfg_q.center_y);

    // stage handshake
    logic [7:1] v_reg;
    logic [7:1] adv;

    always_comb
    begin
        adv[7] = !v_reg[7] || result.ready;
        for (int k = 6; k >= 1; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign query.ready = adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                v_reg[1] <= query.valid;
            end
            for (int k = 2; k <= 7; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 1: offset from center
    logic [1:0]         s1_act_reg;
    logic signed [32:0] s1_dx_reg, s1_dy_reg;
    logic signed [15:0] s1_rxb_reg, s1_ryb_reg;
    logic [30:0]        s1_hwb_reg, s1_hhb_reg;
    logic signed [32:0] s1_dx_next, s1_dy_next;

    always_comb
    begin
        if (query.action == ACT_OVERLAP)
        begin
            s1_dx_next = 33'(query.other_center_x) - 33'(cxa);
            s1_dy_next = 33'(query.other_center_y) - 33'(cya);
        end
        else
        begin
            s1_dx_next = 33'(query.point_x) - 33'(cxa);
            s1_dy_next = 33'(query.point_y) - 33'(cya);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_act_reg <= query.action;
            s1_dx_reg  <= s1_dx_next;
            s1_dy_reg  <= s1_dy_next;
            s1_rxb_reg <= query.other_axis_x;
            s1_ryb_reg <= query.other_axis_y;
            s1_hwb_reg <= query.other_half_width;
            s1_hhb_reg <= query.other_half_height;
        end
    end

    // stage 2: projections and axis products
    logic [1:0]           s2_act_reg;
    logic [30:0]          s2_hwb_reg, s2_hhb_reg;
    logic signed [MW-1:0] s2_m_reg [8];
    logic signed [PW-1:0] s2_p_reg [8];

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_act_reg  <= s1_act_reg;
            s2_hwb_reg  <= s1_hwb_reg;
            s2_hhb_reg  <= s1_hhb_reg;
            s2_m_reg[0] <= MW'(s1_dx_reg) * MW'(rxa);
            s2_m_reg[1] <= MW'(s1_dy_reg) * MW'(rya);
            s2_m_reg[2] <= MW'(s1_dx_reg) * MW'(rya);
            s2_m_reg[3] <= MW'(s1_dy_reg) * MW'(rxa);
            s2_m_reg[4] <= MW'(s1_dx_reg) * MW'(s1_rxb_reg);
            s2_m_reg[5] <= MW'(s1_dy_reg) * MW'(s1_ryb_reg);
            s2_m_reg[6] <= MW'(s1_dx_reg) * MW'(s1_ryb_reg);
            s2_m_reg[7] <= MW'(s1_dy_reg) * MW'(s1_rxb_reg);
            s2_p_reg[0] <= PW'(rxa) * PW'(s1_rxb_reg);
            s2_p_reg[1] <= PW'(rya) * PW'(s1_ryb_reg);
            s2_p_reg[2] <= PW'(rxa) * PW'(s1_ryb_reg);
            s2_p_reg[3] <= PW'(rya) * PW'(s1_rxb_reg);
            s2_p_reg[4] <= PW'(rxa) * PW'(rxa);
            s2_p_reg[5] <= PW'(rya) * PW'(rya);
            s2_p_reg[6] <= PW'(s1_rxb_reg) * PW'(s1_rxb_reg);
            s2_p_reg[7] <= PW'(s1_ryb_reg) * PW'(s1_ryb_reg);
        end
    end

    // stage 3: local coordinates, axis dot and cross
    logic [1:0]           s3_act_reg;
    logic [30:0]          s3_hwb_reg, s3_hhb_reg;
    logic signed [LW-1:0] s3_d_reg [4];
    logic [PW-1:0]        s3_absp_reg, s3_absq_reg, s3_nna_reg, s3_nnb_reg;
    logic signed [PW:0]   s3_p_next, s3_q_next;

    assign s3_p_next = (PW+1)'(s2_p_reg[0]) + (PW+1)'(s2_p_reg[1]);
    assign s3_q_next = (PW+1)'(s2_p_reg[2]) - (PW+1)'(s2_p_reg[3]);

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_act_reg  <= s2_act_reg;
            s3_hwb_reg  <= s2_hwb_reg;
            s3_hhb_reg  <= s2_hhb_reg;
            s3_d_reg[0] <= LW'(s2_m_reg[0]) + LW'(s2_m_reg[1]);
            s3_d_reg[1] <= LW'(s2_m_reg[3]) - LW'(s2_m_reg[2]);
            s3_d_reg[2] <= LW'(s2_m_reg[4]) + LW'(s2_m_reg[5]);
            s3_d_reg[3] <= LW'(s2_m_reg[7]) - LW'(s2_m_reg[6]);
            s3_absp_reg <= s3_p_next[PW] ? PW'(-s3_p_next) : PW'(s3_p_next);
            s3_absq_reg <= s3_q_next[PW] ? PW'(-s3_q_next) : PW'(s3_q_next);
            s3_nna_reg  <= PW'(s2_p_reg[4]) + PW'(s2_p_reg[5]);
            s3_nnb_reg  <= PW'(s2_p_reg[6]) + PW'(s2_p_reg[7]);
        end
    end

    // stage 4: contains test, clamp and round, extent products
    logic [1:0]           s4_act_reg;
    logic                 s4_inside_reg;
    logic signed [RW-1:0] s4_lxr_reg, s4_lyr_reg;
    logic [LW-1:0]        s4_absd_reg [4];
    logic [TPW-1:0]       s4_tp_reg [12];

    logic signed [LW-1:0] ext_w, ext_h, lx_c, ly_c, lx_s, ly_s;
    logic [LW-1:0]        absd [4];
    logic [TPW-1:0]       hwa_t, hha_t, hwb_t, hhb_t;

    always_comb
    begin
        ext_w = LW'($signed({1'b0, cfg_q.half_width})) <<< A;
        ext_h = LW'($signed({1'b0, cfg_q.half_height})) <<< A;
        for (int i = 0; i < 4; i++)
        begin
            absd[i] = s3_d_reg[i][LW-1] ? LW'(-s3_d_reg[i]) : LW'(s3_d_reg[i]);
        end
        if (s3_d_reg[0] > ext_w)
            lx_c = ext_w;
        else if (s3_d_reg[0] < -ext_w)
            lx_c = -ext_w;
        else
            lx_c = s3_d_reg[0];
        if (s3_d_reg[1] > ext_h)
            ly_c = ext_h;
        else if (s3_d_reg[1] < -ext_h)
            ly_c = -ext_h;
        else
            ly_c = s3_d_reg[1];
        lx_s  = (lx_c + RND) >>> A;
        ly_s  = (ly_c + RND) >>> A;
        hwa_t = TPW'(cfg_q.half_width);
        hha_t = TPW'(cfg_q.half_height);
        hwb_t = TPW'(s3_hwb_reg);
        hhb_t = TPW'(s3_hhb_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_act_reg     <= s3_act_reg;
            s4_inside_reg  <= (absd[0] < LW'(ext_w)) && (absd[1] < LW'(ext_h));
            s4_lxr_reg     <= RW'(lx_s);
            s4_lyr_reg     <= RW'(ly_s);
            s4_absd_reg    <= absd;
            s4_tp_reg[0]   <= hwb_t * TPW'(s3_absp_reg);
            s4_tp_reg[1]   <= hhb_t * TPW'(s3_absq_reg);
            s4_tp_reg[2]   <= hwa_t * TPW'(s3_nna_reg);
            s4_tp_reg[3]   <= hwb_t * TPW'(s3_absq_reg);
            s4_tp_reg[4]   <= hhb_t * TPW'(s3_absp_reg);
            s4_tp_reg[5]   <= hha_t * TPW'(s3_nna_reg);
            s4_tp_reg[6]   <= hwa_t * TPW'(s3_absp_reg);
            s4_tp_reg[7]   <= hha_t * TPW'(s3_absq_reg);
            s4_tp_reg[8]   <= hwb_t * TPW'(s3_nnb_reg);
            s4_tp_reg[9]   <= hwa_t * TPW'(s3_absq_reg);
            s4_tp_reg[10]  <= hha_t * TPW'(s3_absp_reg);
            s4_tp_reg[11]  <= hhb_t * TPW'(s3_nnb_reg);
        end
    end

    // stage 5: rotate back, face thresholds
    logic [1:0]           s5_act_reg;
    logic                 s5_inside_reg;
    logic signed [MW-1:0] s5_c_reg [4];
    logic [LW-1:0]        s5_absd_reg [4];
    logic [TW-1:0]        s5_t_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_act_reg    <= s4_act_reg;
            s5_inside_reg <= s4_inside_reg;
            s5_c_reg[0]   <= MW'(s4_lxr_reg) * MW'(rxa);
            s5_c_reg[1]   <= MW'(s4_lyr_reg) * MW'(rya);
            s5_c_reg[2]   <= MW'(s4_lxr_reg) * MW'(rya);
            s5_c_reg[3]   <= MW'(s4_lyr_reg) * MW'(rxa);
            s5_absd_reg   <= s4_absd_reg;
            for (int i = 0; i < 4; i++)
            begin
                s5_t_reg[i] <= TW'(s4_tp_reg[3*i]) + TW'(s4_tp_reg[3*i+1])
                             + TW'(s4_tp_reg[3*i+2]);
            end
        end
    end

    // stage 6: separating face compare, rounding add
    logic [1:0]           s6_act_reg;
    logic                 s6_inside_reg;
    logic                 s6_overlap_reg;
    logic signed [LW-1:0] s6_sx_reg, s6_sy_reg;
    logic [3:0]           sep;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sep[i] = (CMP_W'(s5_absd_reg[i]) << A) >= CMP_W'(s5_t_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s6_act_reg     <= s5_act_reg;
            s6_inside_reg  <= s5_inside_reg;
            s6_overlap_reg <= ~|sep;
            s6_sx_reg      <= LW'(s5_c_reg[0]) - LW'(s5_c_reg[1]) + RND;
            s6_sy_reg      <= LW'(s5_c_reg[2]) + LW'(s5_c_reg[3]) + RND;
        end
    end

    // stage 7: add center, saturate, select by action
    logic                 s7_inside_reg, s7_overlap_reg;
    logic signed [31:0]   s7_cx_reg, s7_cy_reg;
    logic signed [LW-1:0] wx, wy, wx_sat, wy_sat;

    always_comb
    begin
        wx = LW'(cxa) + (s6_sx_reg >>> A);
        wy = LW'(cya) + (s6_sy_reg >>> A);
        if (wx > SAT_MAX)
            wx_sat = SAT_MAX;
        else if (wx < SAT_MIN)
            wx_sat = SAT_MIN;
        else
            wx_sat = wx;
        if (wy > SAT_MAX)
            wy_sat = SAT_MAX;
        else if (wy < SAT_MIN)
            wy_sat = SAT_MIN;
        else
            wy_sat = wy;
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            s7_inside_reg  <= (s6_act_reg == ACT_CONTAINS) && s6_inside_reg;
            s7_overlap_reg <= (s6_act_reg == ACT_OVERLAP) && s6_overlap_reg;
            s7_cx_reg      <= (s6_act_reg == ACT_CLOSEST) ? 32'(wx_sat) : '0;
            s7_cy_reg      <= (s6_act_reg == ACT_CLOSEST) ? 32'(wy_sat) : '0;
        end
    end

    assign result.valid      = v_reg[7];
    assign result.inside_res = s7_inside_reg;
    assign result.closest_x  = s7_cx_reg;
    assign result.closest_y  = s7_cy_reg;
    assign result.overlap    = s7_overlap_reg;

    // checks
    a_one_answer: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.inside_res && result.overlap))
        else $error("two answers in one result");

    a_flag_no_point: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.inside_res || result.overlap))
            |-> (result.closest_x == 0 && result.closest_y == 0))
        else $error("closest point set on a flag result");

    a_fill_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (query.valid && query.ready) |=> v_reg[1])
        else $error("accepted query lost at stage 1");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[1] |-> query.ready)
        else $error("empty pipeline refuses a query");

endmodule

// ----- dv/oriented_box_query_unit_tb.sv -----
// testbench: oriented box query unit checked against a fixed point geometry predictor
module oriented_box_query_unit_tb;
    import obq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [1:0]         act;
        logic signed [31:0] px, py, ocx, ocy;
        logic signed [15:0] oax, oay;
        logic [30:0]        ohw, ohh;
    } query_item_t;

    typedef struct {
        logic               in_box;
        logic signed [31:0] cx, cy;
        logic               ov;
    } answer_t;

    typedef struct {
        query_item_t item;
        bit          typed;
        answer_t     ans;
    } table_row_t;

    typedef struct {
        wide_t cx, cy, rx, ry, ux, uy, hw, hh;
    } box_t;

    localparam int IDLE_LIMIT = 5000;

    logic clk;
    logic rst_n;

    obq_query_if  query ();
    obq_result_if result ();
    obq_cfg_if    cfg ();

    oriented_box_query_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    obq_cfg_t    box_regs;
    answer_t     answers_pending[$];
    bit          cur_typed;
    answer_t     cur_answer;
    int          fail_count = 0;
    int          idle_cycles;
    longint      cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic box_t make_box(logic signed [31:0] cx, logic signed [31:0] cy,
                                      logic signed [15:0] ax, logic signed [15:0] ay,
                                      logic [30:0] hw, logic [30:0] hh);
        box_t b;
        b.cx = cx;
        b.cy = cy;
        b.rx = ax;
        b.ry = ay;
        b.ux = -wide_t'(ay);
        b.uy = ax;
        b.hw = $signed({1'b0, hw});
        b.hh = $signed({1'b0, hh});
        return b;
    endfunction

    function automatic bit face_separates(box_t a, box_t b);
        wide_t nx, ny, e, rn, un, nn, d0, sdist, s1, s2;
        bit all_out;
        for (int f = 0; f < 4; f++)
        begin
            if (f < 2)
            begin
                nx = a.rx; ny = a.ry; e = a.hw;
            end
            else
            begin
                nx = a.ux; ny = a.uy; e = a.hh;
            end
            if (f % 2 == 1)
            begin
                nx = -nx; ny = -ny;
            end
            rn = b.rx * nx + b.ry * ny;
            un = b.ux * nx + b.uy * ny;
            nn = nx * nx + ny * ny;
            d0 = (b.cx - a.cx) * nx + (b.cy - a.cy) * ny;
            all_out = 1'b1;
            for (int k = 0; k < 4; k++)
            begin
                s1 = (k % 2 == 1) ? -1 : 1;
                s2 = (k >= 2) ? -1 : 1;
                sdist = d0 * (wide_t'(1) <<< AXIS_FRAC_BITS) + s1 * b.hw * rn
                        + s2 * b.hh * un - e * nn;
                if (sdist < 0)
                    all_out = 1'b0;
            end
            if (all_out)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic signed [31:0] saturate32(wide_t v);
        if (v > wide_t'(64'sd2147483647))
            return 32'sh7fffffff;
        if (v < -wide_t'(64'sd2147483648))
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic answer_t box_query(obq_cfg_t r, query_item_t q);
        answer_t a;
        box_t me, ot;
        wide_t ew, eh, lx, ly, alx, aly, half;
        a = '{default: '0};
        me = make_box(r.center_x, r.center_y, r.axis_x, r.axis_y, r.half_width,
                      r.half_height);
        half = wide_t'(1) <<< (AXIS_FRAC_BITS - 1);
        ew = me.hw <<< AXIS_FRAC_BITS;
        eh = me.hh <<< AXIS_FRAC_BITS;
        lx = (wide_t'(q.px) - me.cx) * me.rx + (wide_t'(q.py) - me.cy) * me.ry;
        ly = (wide_t'(q.px) - me.cx) * me.ux + (wide_t'(q.py) - me.cy) * me.uy;
        case (q.act)
            ACT_CONTAINS:
            begin
                alx = lx < 0 ? -lx : lx;
                aly = ly < 0 ? -ly : ly;
                a.in_box = (alx < ew) && (aly < eh);
            end
            ACT_CLOSEST:
            begin
                if (lx > ew) lx = ew;
                if (lx < -ew) lx = -ew;
                if (ly > eh) ly = eh;
                if (ly < -eh) ly = -eh;
                lx = (lx + half) >>> AXIS_FRAC_BITS;
                ly = (ly + half) >>> AXIS_FRAC_BITS;
                a.cx = saturate32(me.cx + ((lx * me.rx + ly * me.ux + half) >>> AXIS_FRAC_BITS));
                a.cy = saturate32(me.cy + ((lx * me.ry + ly * me.uy + half) >>> AXIS_FRAC_BITS));
            end
            ACT_OVERLAP:
            begin
                ot = make_box(q.ocx, q.ocy, q.oax, q.oay, q.ohw, q.ohh);
                a.ov = !face_separates(me, ot) && !face_separates(ot, me);
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd11585;
            3: return -16'sd11585;
            4: return 16'($urandom());
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic [30:0] pick_extent();
        case ($urandom_range(0, 4))
            0: return 31'($urandom());
            1: return '0;
            default: return 31'($urandom_range(1, 1 << 20));
        endcase
    endfunction

    function automatic logic signed [31:0] near(logic signed [31:0] c);
        if ($urandom_range(0, 4) == 0)
            return 32'($urandom());
        return c + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    endfunction

    function automatic query_item_t random_item();
        query_item_t q;
        q.act = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        q.px  = near(box_regs.center_x);
        q.py  = near(box_regs.center_y);
        q.ocx = near(box_regs.center_x);
        q.ocy = near(box_regs.center_y);
        q.oax = pick_axis();
        q.oay = pick_axis();
        q.ohw = pick_extent();
        q.ohh = pick_extent();
        return q;
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            REG_CENTER_X:    box_regs.center_x    = value;
            REG_CENTER_Y:    box_regs.center_y    = value;
            REG_AXIS_X:      box_regs.axis_x      = value[15:0];
            REG_AXIS_Y:      box_regs.axis_y      = value[15:0];
            REG_HALF_WIDTH:  box_regs.half_width  = value[30:0];
            REG_HALF_HEIGHT: box_regs.half_height = value[30:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        query.valid <= 1'b0;
        do @(posedge clk); while (answers_pending.size() != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic send_item(query_item_t q, bit typed, answer_t ans);
        query.valid             <= 1'b1;
        query.action            <= q.act;
        query.point_x           <= q.px;
        query.point_y           <= q.py;
        query.other_center_x    <= q.ocx;
        query.other_center_y    <= q.ocy;
        query.other_axis_x      <= q.oax;
        query.other_axis_y      <= q.oay;
        query.other_half_width  <= q.ohw;
        query.other_half_height <= q.ohh;
        cur_typed  <= typed;
        cur_answer <= ans;
        do @(posedge clk); while (!query.ready);
    endtask

    task automatic random_burst(int count);
        int burst;
        answer_t none;
        none = '{default: '0};
        while (count > 0)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && count > 0; i++, count--)
                send_item(random_item(), 1'b0, none);
            if ($urandom_range(0, 2) != 0)
            begin
                query.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    function automatic query_item_t mk(logic [1:0] act, logic signed [31:0] px,
                                       logic signed [31:0] py, logic signed [31:0] ocx,
                                       logic signed [31:0] ocy, logic signed [15:0] oax,
                                       logic signed [15:0] oay, logic [30:0] ohw,
                                       logic [30:0] ohh);
        query_item_t q;
        q = '{act, px, py, ocx, ocy, oax, oay, ohw, ohh};
        return q;
    endfunction

    function automatic answer_t ans(logic in_box, logic signed [31:0] cx,
                                    logic signed [31:0] cy, logic ov);
        answer_t a;
        a = '{in_box, cx, cy, ov};
        return a;
    endfunction

    table_row_t directed_rows[] = '{
        '{mk(ACT_CONTAINS, 0, 0, 0, 0, 0, 0, 0, 0), 1, ans(1, 0, 0, 0)},
        '{mk(ACT_CONTAINS, 32'sh10000, 0, 0, 0, 0, 0, 0, 0), 1, ans(0, 0, 0, 0)},
        '{mk(ACT_CONTAINS, 32'shffff, -32'shffff, 0, 0, 0, 0, 0, 0), 1, ans(1, 0, 0, 0)},
        '{mk(ACT_CONTAINS, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0, 0, 0), 1,
          ans(0, 0, 0, 0)},
        '{mk(ACT_CLOSEST, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 0, 0, 0), 1,
          ans(0, 32'sh10000, 32'sh10000, 0)},
        '{mk(ACT_CLOSEST, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0, 0, 0), 1,
          ans(0, -32'sh10000, -32'sh10000, 0)},
        '{mk(ACT_CLOSEST, 32'sh8000, -32'sh4000, 0, 0, 0, 0, 0, 0), 1,
          ans(0, 32'sh8000, -32'sh4000, 0)},
        '{mk(ACT_OVERLAP, 0, 0, 0, 0, 16384, 0, 65536, 65536), 1, ans(0, 0, 0, 1)},
        '{mk(ACT_OVERLAP, 0, 0, 0, 0, 0, 0, 65536, 65536), 1, ans(0, 0, 0, 0)},
        '{mk(ACT_OVERLAP, 0, 0, 32'sh7fffffff, 32'sh80000000, -16384, 0,
             31'h7fffffff, 31'h7fffffff), 0, ans(0, 0, 0, 0)},
        '{mk(ACT_OVERLAP, 0, 0, 32'sh30000, 0, 11585, 11585, 65536, 65536), 0,
          ans(0, 0, 0, 0)},
        '{mk(ACT_OVERLAP, 0, 0, 32'sh20000, 0, 16384, 0, 65536, 65536), 0, ans(0, 0, 0, 0)},
        '{mk(ACT_OVERLAP, 0, 0, 32'sh1ffff, 0, 0, 16384, 0, 0), 0, ans(0, 0, 0, 0)},
        '{mk(2'd3, -1, -1, -1, -1, -1, -1, 31'h7fffffff, 31'h7fffffff), 1, ans(0, 0, 0, 0)},
        '{mk(ACT_CLOSEST, 32'sh12345, 32'sh7fffffff, 0, 0, 0, 0, 0, 0), 0, ans(0, 0, 0, 0)}
    };

    // receiver stall pattern: quiet stretches, random stalls and periodic stalls take turns
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            cycle_count  <= 0;
        end
        else
        begin
            cycle_count  <= cycle_count + 1;
            case ((cycle_count / 300) % 3)
                0:       result.ready <= 1'b1;
                1:       result.ready <= ($urandom_range(0, 3) != 0);
                default: result.ready <= (cycle_count % 7 < 4);
            endcase
        end
    end

    always @(posedge clk)
    begin
        answer_t got, want;
        query_item_t q;
        if (rst_n && query.valid && query.ready)
        begin
            q = mk(query.action, query.point_x, query.point_y, query.other_center_x,
                   query.other_center_y, query.other_axis_x, query.other_axis_y,
                   query.other_half_width, query.other_half_height);
            answers_pending.push_back(cur_typed ? cur_answer : box_query(box_regs, q));
        end
        if (rst_n && result.valid && result.ready)
        begin
            got = ans(result.inside_res, result.closest_x, result.closest_y, result.overlap);
            if (answers_pending.size() == 0)
            begin
                $display("%0t: unexpected result transaction inside=%0d x=%0d y=%0d ov=%0d",
                         $time, got.in_box, got.cx, got.cy, got.ov);
                fail_count++;
            end
            else
            begin
                want = answers_pending.pop_front();
                if (got.in_box !== want.in_box)
                begin
                    $display("%0t: inside_res expected %0d actual %0d", $time, want.in_box,
                             got.in_box);
                    fail_count++;
                end
                if (got.cx !== want.cx)
                begin
                    $display("%0t: closest_x expected %0d actual %0d", $time, want.cx, got.cx);
                    fail_count++;
                end
                if (got.cy !== want.cy)
                begin
                    $display("%0t: closest_y expected %0d actual %0d", $time, want.cy, got.cy);
                    fail_count++;
                end
                if (got.ov !== want.ov)
                begin
                    $display("%0t: overlap expected %0d actual %0d", $time, want.ov, got.ov);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (query.valid && query.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cur_typed   = 1'b0;
        cur_answer  = '{default: '0};
        box_regs    = '{center_x: 0, center_y: 0, axis_x: 16384, axis_y: 0,
                        half_width: 65536, half_height: 65536};
        query.valid             <= 1'b0;
        query.action            <= '0;
        query.point_x           <= '0;
        query.point_y           <= '0;
        query.other_center_x    <= '0;
        query.other_center_y    <= '0;
        query.other_axis_x      <= '0;
        query.other_axis_y      <= '0;
        query.other_half_width  <= '0;
        query.other_half_height <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].ans);
        random_burst(60);
        wait_drained();

        // extreme box: far corner, negative axis, widest extents
        write_reg(REG_CENTER_X, 32'h7fffffff);
        write_reg(REG_CENTER_Y, 32'h80000000);
        write_reg(REG_AXIS_X, 32'h0000c000);
        write_reg(REG_AXIS_Y, 32'h00000000);
        write_reg(REG_HALF_WIDTH, 32'h7fffffff);
        write_reg(REG_HALF_HEIGHT, 32'h7fffffff);
        random_burst(100);
        wait_drained();

        // degenerate box: zero axis and zero extents
        write_reg(REG_CENTER_X, 32'h80000000);
        write_reg(REG_CENTER_Y, 32'h7fffffff);
        write_reg(REG_AXIS_X, 32'h0);
        write_reg(REG_HALF_WIDTH, 32'h0);
        write_reg(REG_HALF_HEIGHT, 32'h0);
        random_burst(80);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_CENTER_X, $urandom());
            write_reg(REG_CENTER_Y, $urandom());
            write_reg(REG_AXIS_X, 32'(pick_axis()));
            write_reg(REG_AXIS_Y, 32'(pick_axis()));
            write_reg(REG_HALF_WIDTH, 32'(pick_extent()));
            write_reg(REG_HALF_HEIGHT, 32'(pick_extent()));
            random_burst(90);
            wait_drained();
        end

        query.valid <= 1'b0;
        do @(posedge clk); while (answers_pending.size() != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
